/* rtl/olst_pkg.sv */
`default_nettype none

package olst_pkg;

    localparam int DEPTH     = 64;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);

    typedef logic [WORD_BITS-1:0] t_word;

    // Per-cycle command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_SHIFT_DOWN,
        CMD_ROTATE,
        CMD_MARK,
        CMD_SORT
    } t_cell_cmd;

    typedef struct packed {
        t_cell_cmd        cmd;
        logic [CNT_W-1:0] pos;
        logic [CNT_W-1:0] count;
        t_word            operand;
        logic             phase;
    } t_cell_ctl;

endpackage

`default_nettype wire

/* rtl/olst_cell.sv */
`default_nettype none

module olst_cell (
    input  wire                       i_clk,
    input  olst_pkg::t_cell_ctl       i_ctl,
    input  wire [olst_pkg::IDX_W-1:0] i_index,
    input  olst_pkg::t_word           i_left_word,
    input  wire                       i_left_keep,
    input  olst_pkg::t_word           i_right_word,
    input  wire                       i_right_keep,
    output olst_pkg::t_word           o_word,
    output logic                      o_keep
);
    import olst_pkg::*;

    t_word            r_word;
    t_word            n_word;
    logic             r_keep;
    logic             n_keep;
    logic [CNT_W-1:0] idx;

    assign idx = CNT_W'(i_index);

    always_comb begin
        n_word = r_word;
        n_keep = r_keep;
        unique case (i_ctl.cmd)
            CMD_HOLD: begin
            end
            CMD_INSERT: begin
                if (idx == i_ctl.pos) begin
                    n_word = i_ctl.operand;
                end else if (idx > i_ctl.pos) begin
                    n_word = i_left_word;
                end
            end
            CMD_SHIFT_DOWN: begin
                if (idx >= i_ctl.pos) begin
                    n_word = i_right_word;
                end
            end
            CMD_ROTATE: begin
                n_word = i_right_word;
            end
            CMD_MARK: begin
                n_keep = (idx < i_ctl.count) && (r_word != i_ctl.operand);
            end
            CMD_SORT: begin
                // Swap a hole with a kept word of the partner cell
                if (i_index[0] == i_ctl.phase) begin
                    if (!r_keep && i_right_keep) begin
                        n_word = i_right_word;
                        n_keep = 1'b1;
                    end
                end else begin
                    if (!i_left_keep && r_keep) begin
                        n_word = i_left_word;
                        n_keep = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_keep <= n_keep;
    end

    assign o_word = r_word;
    assign o_keep = r_keep;

endmodule

`default_nettype wire

/* rtl/ordered_list_engine.sv */
`default_nettype none

// Ordered list of up to 64 signed 32-bit words held in a chain of cells, one
// word per cell. Raise start with mode, position and operand while busy is
// low; the command is taken at that edge. Every command returns exactly one
// result: o_valid is high for a single cycle with o_word_out, o_found,
// o_found_position, o_status and o_entry_count, and there is no way to hold
// it off, so capture it in that cycle. Push, insert and every rejected command
// (bad index, full, empty, unused mode) never leave idle: the result shows
// on the next cycle and busy stays low, so these may be issued back to back.
// Pop, read and find rotate the whole chain once past cell 0, one cell per
// cycle, before the result is returned; delete rotates and then shifts the upper
// cells down. Remove-all marks the cells to keep (non-matching words inside
// the list), runs 64 odd-even exchange rounds that bubble the holes to the top
// end while keeping the order of the kept words, then recounts. The chain
// length sets how long these commands run. After reset the list is empty; no
// clearing pass is run.

module ordered_list_engine (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire        [2:0]  i_mode,
    input  wire        [6:0]  i_position,
    input  wire signed [31:0] i_operand,
    output logic              o_valid,
    output logic signed [31:0] o_word_out,
    output logic              o_found,
    output logic       [5:0]  o_found_position,
    output logic       [1:0]  o_status,
    output logic       [6:0]  o_entry_count
);
    import olst_pkg::*;

    localparam logic [2:0] MODE_PUSH   = 3'd0;
    localparam logic [2:0] MODE_INSERT = 3'd1;
    localparam logic [2:0] MODE_POP    = 3'd2;
    localparam logic [2:0] MODE_DELETE = 3'd3;
    localparam logic [2:0] MODE_REMOVE = 3'd4;
    localparam logic [2:0] MODE_FIND   = 3'd5;
    localparam logic [2:0] MODE_READ   = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_SORT,
        S_COUNT
    } t_state;

    t_state           r_state,   n_state;
    logic             r_busy,    n_busy;
    logic             r_valid,   n_valid;
    logic [CNT_W-1:0] r_count,   n_count;
    logic [IDX_W-1:0] r_step,    n_step;
    logic [2:0]       r_mode,    n_mode;
    logic [CNT_W-1:0] r_pos,     n_pos;
    t_word            r_operand, n_operand;
    t_word            r_word,    n_word;
    logic             r_hit,     n_hit;
    logic [IDX_W-1:0] r_fpos,    n_fpos;
    logic [1:0]       r_status,  n_status;

    t_cell_ctl        cell_ctl;
    t_word            cell_word [DEPTH];
    logic [DEPTH-1:0] cell_keep;
    logic [CNT_W-1:0] sort_count;
    logic             accept;

    // ------------------------------------------------------------------
    // Cell chain: each cell sees its neighbors; the top cell's right side wraps to
    // cell 0 so that a rotation walks every word past cell 0.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word left_word;
        logic  left_keep;
        t_word right_word;
        logic  right_keep;

        if (g == 0) begin : g_first
            assign left_word = '0;
            assign left_keep = 1'b1;
        end else begin : g_mid_l
            assign left_word = cell_word[g-1];
            assign left_keep = cell_keep[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_word = cell_word[0];
            assign right_keep = 1'b0;
        end else begin : g_mid_r
            assign right_word = cell_word[g+1];
            assign right_keep = cell_keep[g+1];
        end

        olst_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_index      (IDX_W'(g)),
            .i_left_word  (left_word),
            .i_left_keep  (left_keep),
            .i_right_word (right_word),
            .i_right_keep (right_keep),
            .o_word       (cell_word[g]),
            .o_keep       (cell_keep[g])
        );
    end

    // After the exchange rounds the kept words form a prefix; the edge
    // between the last kept cell and the first hole gives the new count.
    always_comb begin
        sort_count = '0;
        for (int k = 0; k < DEPTH - 1; k++) begin
            if (cell_keep[k] && !cell_keep[k+1]) begin
                sort_count = sort_count | CNT_W'(k + 1);
            end
        end
        if (cell_keep[DEPTH-1]) begin
            sort_count = sort_count | CNT_W'(DEPTH);
        end
    end

    assign accept = start && !r_busy;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_valid   = 1'b0;
        n_count   = r_count;
        n_step    = r_step;
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_operand = r_operand;
        n_word    = r_word;
        n_hit     = r_hit;
        n_fpos    = r_fpos;
        n_status  = r_status;

        cell_ctl.cmd     = CMD_HOLD;
        cell_ctl.pos     = r_pos;
        cell_ctl.count   = r_count;
        cell_ctl.operand = r_operand;
        cell_ctl.phase   = r_step[0];

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mode    = i_mode;
                    n_pos     = i_position;
                    n_operand = i_operand[WORD_BITS-1:0];
                    n_word    = '0;
                    n_hit     = 1'b0;
                    n_fpos    = '0;
                    n_status  = ST_OK;
                    n_step    = '0;
                    unique case (i_mode) inside
                        MODE_PUSH: begin
                            n_valid = 1'b1;
                            if (r_count == CNT_FULL) begin
                                n_status = ST_FULL;
                            end else begin
                                // Append: insert at the current end
                                cell_ctl.cmd     = CMD_INSERT;
                                cell_ctl.pos     = r_count;
                                cell_ctl.operand = i_operand[WORD_BITS-1:0];
                                n_count          = r_count + CNT_W'(1);
                            end
                        end
                        MODE_INSERT: begin
                            n_valid = 1'b1;
                            if (i_position > r_count) begin
                                n_status = ST_RANGE;
                            end else if (r_count == CNT_FULL) begin
                                n_status = ST_FULL;
                            end else begin
                                cell_ctl.cmd     = CMD_INSERT;
                                cell_ctl.pos     = i_position;
                                cell_ctl.operand = i_operand[WORD_BITS-1:0];
                                n_count          = r_count + CNT_W'(1);
                            end
                        end
                        MODE_POP: begin
                            if (r_count == '0) begin
                                n_valid  = 1'b1;
                                n_status = ST_EMPTY;
                            end else begin
                                n_pos   = r_count - CNT_W'(1);
                                n_state = S_SCAN;
                            end
                        end
                        MODE_DELETE, MODE_READ: begin
                            if (i_position >= r_count) begin
                                n_valid  = 1'b1;
                                n_status = ST_RANGE;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        MODE_REMOVE: begin
                            // Flag kept cells now, compact over the next rounds
                            cell_ctl.cmd     = CMD_MARK;
                            cell_ctl.operand = i_operand[WORD_BITS-1:0];
                            n_state          = S_SORT;
                        end
                        MODE_FIND: begin
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_valid = 1'b1;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Cell 0 holds entry r_step; rotate one cell per cycle
                cell_ctl.cmd = CMD_ROTATE;
                if ((r_mode == MODE_POP || r_mode == MODE_DELETE || r_mode == MODE_READ)
                        && CNT_W'(r_step) == r_pos) begin
                    n_word = cell_word[0];
                end
                if (r_mode == MODE_FIND && !r_hit && CNT_W'(r_step) < r_count
                        && cell_word[0] == r_operand) begin
                    n_hit  = 1'b1;
                    n_fpos = r_step;
                end
                n_step = r_step + IDX_W'(1);
                if (r_step == STEP_LAST) begin
                    if (r_mode == MODE_DELETE) begin
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_IDLE;
                        n_valid = 1'b1;
                        if (r_mode == MODE_POP) begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                end
            end

            S_SHIFT: begin
                // Close the gap: cells at and above the index take their upper neighbor
                cell_ctl.cmd = CMD_SHIFT_DOWN;
                n_count      = r_count - CNT_W'(1);
                n_state      = S_IDLE;
                n_valid      = 1'b1;
            end

            S_SORT: begin
                cell_ctl.cmd = CMD_SORT;
                n_step       = r_step + IDX_W'(1);
                if (r_step == STEP_LAST) begin
                    n_state = S_COUNT;
                end
            end

            S_COUNT: begin
                n_count = sort_count;
                n_state = S_IDLE;
                n_valid = 1'b1;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_busy = (n_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_count <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_valid <= n_valid;
            r_count <= n_count;
            r_step  <= n_step;
        end
        r_mode    <= n_mode;
        r_pos     <= n_pos;
        r_operand <= n_operand;
        r_word    <= n_word;
        r_hit     <= n_hit;
        r_fpos    <= n_fpos;
        r_status  <= n_status;
    end

    assign busy             = r_busy;
    assign o_valid          = r_valid;
    assign o_word_out       = 32'(r_word);
    assign o_found          = r_hit;
    assign o_found_position = 6'(r_fpos);
    assign o_status         = r_status;
    assign o_entry_count    = 7'(r_count);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("entry count above depth");

    a_push_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == MODE_PUSH) |=> (o_valid && !busy))
        else $error("push did not finish in one cycle");

    a_found_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_status == ST_OK && 7'(o_found_position) < o_entry_count))
        else $error("found index outside the list");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !busy && o_entry_count == 7'd0))
        else $error("outputs not cleared by reset");

endmodule

`default_nettype wire
